/* hw/rtl/x86alu_pkg.sv */
package x86alu_pkg;

   localparam int unsigned OPERAND_WIDTH = 32;
   localparam int unsigned RESULT_WIDTH  = 64;
   localparam int unsigned FUNC_WIDTH    = 4;
   localparam int unsigned SIZE_WIDTH    = 2;
   localparam int unsigned SHIFT_WIDTH   = 5;

   // req_tdata: func, src_operand, dest_operand, size_code, padded to bytes
   localparam int unsigned REQ_BITS  = FUNC_WIDTH + 2 * OPERAND_WIDTH + SIZE_WIDTH;
   localparam int unsigned REQ_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   // rsp_tdata: result_value, then CF, PF, ZF, SF, OF
   localparam int unsigned RSP_BITS  = RESULT_WIDTH + 5;
   localparam int unsigned RSP_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FUNC_WIDTH-1:0] FUNC_ADD = 4'd0;
   localparam logic [FUNC_WIDTH-1:0] FUNC_ADC = 4'd1;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SUB = 4'd2;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SBB = 4'd3;
   localparam logic [FUNC_WIDTH-1:0] FUNC_AND = 4'd4;
   localparam logic [FUNC_WIDTH-1:0] FUNC_OR  = 4'd5;
   localparam logic [FUNC_WIDTH-1:0] FUNC_XOR = 4'd6;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SHL = 4'd7;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SAL = 4'd8;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SHR = 4'd9;
   localparam logic [FUNC_WIDTH-1:0] FUNC_SAR = 4'd10;
   localparam logic [FUNC_WIDTH-1:0] FUNC_MUL = 4'd11;

   localparam logic [SIZE_WIDTH-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_WIDTH-1:0] SIZE_WORD = 2'd1;

   typedef struct packed {
      logic cf;
      logic pf;
      logic zf;
      logic sf;
      logic of;
   } flags_type;

   typedef struct packed {
      logic [SIZE_WIDTH-1:0]    size_code;
      logic [OPERAND_WIDTH-1:0] dest_operand;
      logic [OPERAND_WIDTH-1:0] src_operand;
      logic [FUNC_WIDTH-1:0]    func;
   } req_type;

endpackage

/* hw/rtl/x86_integer_alu_with_flags_unit.sv */
// Channel  Dir  Handshake              Payload (low bit first)
// req_     in   req_tvalid/req_tready  func, src_operand, dest_operand, size_code
// rsp_     out  rsp_tvalid/rsp_tready  result_value, CF, PF, ZF, SF, OF
//
// One item per cycle while rsp_tready keeps the result register free; an accepted
// item goes into the input register, then through the single ALU stage into the
// result register, where rsp_tvalid shows it.
// The flag register updates as an item leaves the input register, so adc/sbb
// see the flags of the item just before them. Reset clears the flags and both
// valid bits. A stalled result holds the input register, which drops req_tready once full.
module x86_integer_alu_with_flags_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // func[3:0], src_operand[35:4], dest_operand[67:36], size_code[69:68]
   input  logic [x86alu_pkg::REQ_WIDTH-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // result_value[63:0], carry[64], parity[65], zero[66], sign[67], overflow[68]
   output logic [x86alu_pkg::RSP_WIDTH-1:0] rsp_tdata
);
   import x86alu_pkg::*;

   logic                     in_valid_ff;
   req_type                  in_data_ff;
   logic                     out_valid_ff;
   logic [RESULT_WIDTH-1:0]  out_result_ff;
   flags_type                flags_ff;
   flags_type                flags_in;
   logic [RESULT_WIDTH-1:0]  result_in;
   logic                     out_load;
   logic                     advance;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance) begin
            flags_ff <= flags_in;
         end
      end
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_type'(req_tdata[REQ_BITS-1:0]);
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   // ALU stage
   always_comb begin
      logic [OPERAND_WIDTH-1:0] mask;
      logic [5:0]               width_n;
      logic [4:0]               top_idx;
      logic [OPERAND_WIDTH-1:0] s;
      logic [OPERAND_WIDTH-1:0] d;
      logic [SHIFT_WIDTH-1:0]   cnt;
      logic                     cin;
      logic [OPERAND_WIDTH:0]   sum;
      logic [OPERAND_WIDTH:0]   sub_t;
      logic [OPERAND_WIDTH+1:0] diff;
      logic [OPERAND_WIDTH-1:0] r32;
      logic [RESULT_WIDTH-1:0]  ext;
      logic [5:0]               shl_idx;
      logic [4:0]               shr_idx;
      logic                     neg;
      logic                     in_range;
      logic [RESULT_WIDTH-1:0]  prod;
      logic                     set_pzs;

      unique case (in_data_ff.size_code)
         SIZE_BYTE: begin
            mask = 32'h0000_00FF; width_n = 6'd8;  top_idx = 5'd7;
         end
         SIZE_WORD: begin
            mask = 32'h0000_FFFF; width_n = 6'd16; top_idx = 5'd15;
         end
         default: begin
            mask = 32'hFFFF_FFFF; width_n = 6'd32; top_idx = 5'd31;
         end
      endcase

      s        = in_data_ff.src_operand & mask;
      d        = in_data_ff.dest_operand & mask;
      cnt      = in_data_ff.src_operand[SHIFT_WIDTH-1:0];
      in_range = {1'b0, cnt} <= width_n;
      cin      = (in_data_ff.func == FUNC_ADC || in_data_ff.func == FUNC_SBB)
                 ? flags_ff.cf : 1'b0;

      sum     = {1'b0, d} + {1'b0, s} + {{OPERAND_WIDTH{1'b0}}, cin};
      sub_t   = {1'b0, s} + {{OPERAND_WIDTH{1'b0}}, cin};
      diff    = {2'b00, d} - {1'b0, sub_t};
      shl_idx = width_n - {1'b0, cnt};
      shr_idx = cnt - 5'd1;
      neg     = (in_data_ff.func == FUNC_SAR) && d[top_idx];
      // sign fill reaches past bit 31 so a full-width sar shifts ones in
      ext     = {{(RESULT_WIDTH-OPERAND_WIDTH){neg}}, (neg ? (d | ~mask) : d)};
      prod    = {{OPERAND_WIDTH{1'b0}}, d} * {{OPERAND_WIDTH{1'b0}}, s};

      flags_in  = flags_ff;
      r32       = '0;
      result_in = '0;
      set_pzs   = 1'b1;

      unique case (in_data_ff.func)
         FUNC_ADD, FUNC_ADC: begin
            r32         = sum[OPERAND_WIDTH-1:0] & mask;
            // carry out of the sized top bit lands one above it
            flags_in.cf = (in_data_ff.size_code == SIZE_BYTE) ? sum[8] :
                          (in_data_ff.size_code == SIZE_WORD) ? sum[16] : sum[32];
            flags_in.of = (d[top_idx] ^ r32[top_idx]) & (s[top_idx] ^ r32[top_idx]);
         end
         FUNC_SUB, FUNC_SBB: begin
            r32         = diff[OPERAND_WIDTH-1:0] & mask;
            flags_in.cf = diff[OPERAND_WIDTH+1];
            flags_in.of = (d[top_idx] ^ s[top_idx]) & (d[top_idx] ^ r32[top_idx]);
         end
         FUNC_AND, FUNC_OR, FUNC_XOR: begin
            r32 = (in_data_ff.func == FUNC_AND) ? (d & s) :
                  (in_data_ff.func == FUNC_OR)  ? (d | s) : (d ^ s);
            flags_in.cf = 1'b0;
            flags_in.of = 1'b0;
         end
         FUNC_SHL, FUNC_SAL: begin
            r32 = (d << cnt) & mask;
            if (cnt != '0) begin
               flags_in.cf = in_range ? d[shl_idx[4:0]] : 1'b0;
            end
            flags_in.of = 1'b0;
         end
         FUNC_SHR, FUNC_SAR: begin
            if ({1'b0, cnt} < width_n) begin
               r32 = OPERAND_WIDTH'(ext >> cnt) & mask;
            end else begin
               r32 = neg ? mask : '0;
            end
            if (cnt != '0) begin
               flags_in.cf = in_range ? d[shr_idx] : 1'b0;
            end
            flags_in.of = 1'b0;
         end
         FUNC_MUL: begin
            set_pzs     = 1'b0;
            flags_in.cf = (in_data_ff.size_code == SIZE_BYTE) ? (prod[15:8] != '0) :
                          (in_data_ff.size_code == SIZE_WORD) ? (prod[31:16] != '0) :
                          (prod[63:32] != '0);
            flags_in.of = flags_in.cf;
         end
         default: begin
            set_pzs = 1'b0;
         end
      endcase

      if (in_data_ff.func == FUNC_MUL) begin
         result_in = prod;
      end else begin
         result_in = {{(RESULT_WIDTH-OPERAND_WIDTH){1'b0}}, r32};
      end

      if (set_pzs) begin
         flags_in.pf = ~(^r32[7:0]);
         flags_in.zf = (r32 == '0);
         flags_in.sf = r32[top_idx];
      end
   end

   // flag outputs show the flag register, which is the state after this item
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_WIDTH-RSP_BITS){1'b0}},
                        flags_ff.of, flags_ff.sf, flags_ff.zf, flags_ff.pf, flags_ff.cf,
                        out_result_ff};

endmodule
